// File: rtl/core/cpa_pkg.sv
// Shared types, constants and functions of the color pair allocator.
// Used by cpa_cell and color_pair_allocator; depends on nothing else.
package cpa_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int INDEX_WIDTH = $clog2(TABLE_DEPTH);
   localparam int PAIR_LIMIT  = 64;

   localparam logic [3:0] SCORE_START  = 4'hF;
   localparam logic [3:0] PEN_BG_BLACK = 4'd3;
   localparam logic [3:0] PEN_BG_WHITE = 4'd2;
   localparam logic [3:0] PEN_FG_BLACK = 4'd5;
   localparam logic [3:0] PEN_FG_WHITE = 4'd3;
   localparam logic [2:0] COLOR_BLACK  = 3'd0;
   localparam logic [2:0] COLOR_WHITE  = 3'd7;

   typedef enum logic [1:0] {
      OUTCOME_HIT    = 2'd0,
      OUTCOME_NEW    = 2'd1,
      OUTCOME_SUBST  = 2'd2,
      OUTCOME_REJECT = 2'd3
   } cpa_outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } cpa_state_type;

   typedef struct packed {
      logic       live;
      logic [2:0] fg;
      logic [2:0] bg;
      logic [3:0] best_score;
      logic [7:0] best_pair;
      logic       hit;
      logic [7:0] hit_pair;
   } cpa_token_type;

   typedef struct packed {
      logic                   en;
      logic [INDEX_WIDTH-1:0] index;
      logic [7:0]             pair;
   } cpa_write_type;

   function automatic logic [2:0] color_perm(input logic [2:0] color);
      logic [2:0] mapped;
      case (color)
         3'd0: mapped = 3'd0;
         3'd1: mapped = 3'd4;
         3'd2: mapped = 3'd2;
         3'd3: mapped = 3'd6;
         3'd4: mapped = 3'd1;
         3'd5: mapped = 3'd5;
         3'd6: mapped = 3'd3;
         default: mapped = 3'd7;
      endcase
      return mapped;
   endfunction

endpackage

// File: rtl/core/cpa_cell.sv
// One cell of the pair store chain: holds one table entry, scores it against
// the passing request word and hands the word on. Depends on cpa_pkg.
module cpa_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cpa_pkg::INDEX_WIDTH-1:0] cell_index,
   input  cpa_pkg::cpa_token_type         tok_in,
   input  cpa_pkg::cpa_write_type         wr,
   output cpa_pkg::cpa_token_type         tok_out
);

   logic                  valid_ff, valid_in;
   logic [7:0]            pair_ff, pair_in;
   cpa_pkg::cpa_token_type tok_ff, tok_in_next;
   logic [3:0]            score;
   logic                  wr_hit;

   always_comb begin
      score = 4'd0;
      if (tok_in.bg != cell_index[2:0]) begin
         if (tok_in.bg == cpa_pkg::COLOR_BLACK) begin
            score = score + cpa_pkg::PEN_BG_BLACK;
         end else if (tok_in.bg == cpa_pkg::COLOR_WHITE) begin
            score = score + cpa_pkg::PEN_BG_WHITE;
         end
      end
      if (tok_in.fg != cell_index[5:3]) begin
         if (tok_in.fg == cpa_pkg::COLOR_BLACK) begin
            score = score + cpa_pkg::PEN_FG_BLACK;
         end else if (tok_in.fg == cpa_pkg::COLOR_WHITE) begin
            score = score + cpa_pkg::PEN_FG_WHITE;
         end
      end
   end

   always_comb begin
      tok_in_next = tok_in;
      if (valid_ff) begin
         if ({tok_in.fg, tok_in.bg} == cell_index) begin
            tok_in_next.hit      = 1'b1;
            tok_in_next.hit_pair = pair_ff;
         end
         if (score < tok_in.best_score) begin
            tok_in_next.best_score = score;
            tok_in_next.best_pair  = pair_ff;
         end
      end
   end

   assign wr_hit   = wr.en && (wr.index == cell_index);
   assign valid_in = valid_ff | wr_hit;
   assign pair_in  = wr_hit ? wr.pair : pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         tok_ff.live <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_next;
      end
      pair_ff <= pair_in;
   end

   assign tok_out = tok_ff;

endmodule

// File: rtl/core/color_pair_allocator.sv
// Top level of the color pair allocator: request control, the chain of
// store cells and the response register. Depends on cpa_pkg and cpa_cell.
//
// A request word carries a foreground and a background color. The response
// word gives the pair number, the outcome, the program flag and, for a newly
// allocated pair, both colors after the terminal permutation.
// An in-range request enters the chain of 64 store cells and moves one cell
// per cycle; after the last cell its result is registered in the result
// registers, and from the done state the response word is loaded into the
// output register. A rejected request with a color outside 0..7 does not
// enter the chain; its result is registered at acceptance and then loaded
// into the output register from the done state, as for any other request.
// Only one request is in progress at a time; req_stall is high from
// acceptance until the response is loaded into the output register.
// If the receiver holds rsp_stall, the response word stays unchanged, a
// finished result waits, and no new request is taken until it is loaded.
// Reset clears every store entry, the entry count and all handshake state;
// the block takes requests in the first cycle after reset.
module color_pair_allocator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_fg_color,
   input  logic [7:0] req_bg_color,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_pair_number,
   output logic [1:0] rsp_outcome,
   output logic       rsp_program_pair,
   output logic [2:0] rsp_mapped_fg,
   output logic [2:0] rsp_mapped_bg
);

   cpa_pkg::cpa_state_type   state_ff, state_in;
   logic [6:0]               count_ff, count_in;
   logic [7:0]               res_pair_ff, res_pair_in;
   cpa_pkg::cpa_outcome_type res_outcome_ff, res_outcome_in;
   logic                     res_prog_ff, res_prog_in;
   logic [2:0]               res_mfg_ff, res_mfg_in;
   logic [2:0]               res_mbg_ff, res_mbg_in;
   logic                     rsp_valid_ff;
   logic [7:0]               rsp_pair_ff;
   cpa_pkg::cpa_outcome_type rsp_outcome_ff;
   logic                     rsp_prog_ff;
   logic [2:0]               rsp_mfg_ff, rsp_mbg_ff;

   logic                     req_accept, in_range, rsp_load, has_room;
   logic [8:0]               next_count;
   cpa_pkg::cpa_write_type   wr;
   cpa_pkg::cpa_token_type   chain_tok [0:cpa_pkg::TABLE_DEPTH];
   cpa_pkg::cpa_token_type   last_tok;

   assign req_stall  = (state_ff != cpa_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign in_range   = (req_fg_color[7:3] == 5'd0) && (req_bg_color[7:3] == 5'd0);

   always_comb begin
      chain_tok[0].live       = req_accept && in_range;
      chain_tok[0].fg         = req_fg_color[2:0];
      chain_tok[0].bg         = req_bg_color[2:0];
      chain_tok[0].best_score = cpa_pkg::SCORE_START;
      chain_tok[0].best_pair  = 8'd0;
      chain_tok[0].hit        = 1'b0;
      chain_tok[0].hit_pair   = 8'd0;
   end

   for (genvar g = 0; g < cpa_pkg::TABLE_DEPTH; g++) begin : g_cell
      cpa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (cpa_pkg::INDEX_WIDTH'(g)),
         .tok_in     (chain_tok[g]),
         .wr         (wr),
         .tok_out    (chain_tok[g+1])
      );
   end

   assign last_tok   = chain_tok[cpa_pkg::TABLE_DEPTH];
   assign next_count = {2'b00, count_ff} + 9'd1;
   assign has_room   = next_count < 9'(cpa_pkg::PAIR_LIMIT);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      res_pair_in    = res_pair_ff;
      res_outcome_in = res_outcome_ff;
      res_prog_in    = res_prog_ff;
      res_mfg_in     = res_mfg_ff;
      res_mbg_in     = res_mbg_ff;
      wr.en          = 1'b0;
      wr.index       = {last_tok.fg, last_tok.bg};
      wr.pair        = 8'd0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         cpa_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (in_range) begin
                  state_in = cpa_pkg::ST_SCAN;
               end else begin
                  res_pair_in    = 8'd0;
                  res_outcome_in = cpa_pkg::OUTCOME_REJECT;
                  res_prog_in    = 1'b0;
                  res_mfg_in     = 3'd0;
                  res_mbg_in     = 3'd0;
                  state_in       = cpa_pkg::ST_DONE;
               end
            end
         end
         cpa_pkg::ST_SCAN: begin
            if (last_tok.live) begin
               res_prog_in = 1'b0;
               res_mfg_in  = 3'd0;
               res_mbg_in  = 3'd0;
               if (last_tok.hit) begin
                  res_pair_in    = last_tok.hit_pair;
                  res_outcome_in = cpa_pkg::OUTCOME_HIT;
               end else if (has_room) begin
                  res_pair_in    = next_count[7:0];
                  res_outcome_in = cpa_pkg::OUTCOME_NEW;
                  res_prog_in    = 1'b1;
                  res_mfg_in     = cpa_pkg::color_perm(last_tok.fg);
                  res_mbg_in     = cpa_pkg::color_perm(last_tok.bg);
                  wr.en          = 1'b1;
                  wr.pair        = next_count[7:0];
                  count_in       = next_count[6:0];
               end else begin
                  res_pair_in    = last_tok.best_pair;
                  res_outcome_in = cpa_pkg::OUTCOME_SUBST;
                  wr.en          = 1'b1;
                  wr.pair        = last_tok.best_pair;
                  count_in       = next_count[6:0];
               end
               state_in = cpa_pkg::ST_DONE;
            end
         end
         cpa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = cpa_pkg::ST_IDLE;
            end
         end
         default: state_in = cpa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpa_pkg::ST_IDLE;
         count_ff     <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      res_pair_ff    <= res_pair_in;
      res_outcome_ff <= res_outcome_in;
      res_prog_ff    <= res_prog_in;
      res_mfg_ff     <= res_mfg_in;
      res_mbg_ff     <= res_mbg_in;
      if (rsp_load) begin
         rsp_pair_ff    <= res_pair_ff;
         rsp_outcome_ff <= res_outcome_ff;
         rsp_prog_ff    <= res_prog_ff;
         rsp_mfg_ff     <= res_mfg_ff;
         rsp_mbg_ff     <= res_mbg_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pair_number  = rsp_pair_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_program_pair = rsp_prog_ff;
   assign rsp_mapped_fg    = rsp_mfg_ff;
   assign rsp_mapped_bg    = rsp_mbg_ff;

endmodule
